// ----- rtl/core/frac_pkg.sv -----
// Shared types and codes for the fraction reduce and arithmetic core.
package frac_pkg;

  localparam int unsigned FIELD_BITS = 32;
  localparam int unsigned KIND_BITS  = 3;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_REDUCED  = 3'd0,
    KIND_SUM      = 3'd1,
    KIND_DIFF     = 3'd2,
    KIND_NEG      = 3'd3,
    KIND_PRODUCT  = 3'd4,
    KIND_QUOTIENT = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    OP_EUC,
    OP_QN,
    OP_QD
  } div_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EUC_TEST,
    ST_DIV_MAGA,
    ST_DIV_MAGB,
    ST_DIV_RUN,
    ST_DIV_SIGN,
    ST_RED,
    ST_MUL_SETUP,
    ST_MUL_RUN,
    ST_SUM,
    ST_DIFF,
    ST_NEG,
    ST_EMIT
  } state_t;

endpackage

// ----- rtl/core/fraction_reduce_and_arithmetic_core.sv -----
// Fraction reduction by Euclid's algorithm and fraction arithmetic on one shared adder.
//
// Usage:
//   The in_ channel takes one item: two fractions as four signed 32-bit fields.
//   The first fraction is reduced by its Euclid divisor, then six result items
//   leave on the out_ channel in order: reduced first, sum, difference, negated
//   first, product, quotient (tlast set on the quotient). None but the first is
//   reduced; all arithmetic wraps at WORD_BITS bits.
//   Every step runs on one (WORD_BITS+1)-bit add/subtract unit under a sequencer:
//   a division runs two magnitude steps, one bit per cycle and a sign fix,
//   a multiplication a setup step and then shift and add.
//   How long an item takes is set by the Euclid loop, whose number of remainder
//   steps reaches up to about 46 at 32 bits.
//   in_tready is high only while idle; the next item is taken the cycle after
//   the quotient is taken.
//   A stalled receiver holds the block in its output phase with the current
//   result item held; nothing is lost.
//   Reset (rst_n low, synchronous) returns to idle and drops any item in work.
module fraction_reduce_and_arithmetic_core #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [31:0] first_numerator, [63:32] first_denominator,
  // [95:64] second_numerator, [127:96] second_denominator
  input  logic [127:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] result_numerator, [63:32] result_denominator
  output logic [63:0]  out_tdata,
  // [2:0] result_kind, [3] zero_divisor
  output logic [3:0]   out_tuser,
  // last_result
  output logic         out_tlast
);

  localparam int unsigned W     = WORD_BITS;
  localparam int unsigned AW    = WORD_BITS + 1;
  localparam int unsigned CNT_W = $clog2(WORD_BITS);
  localparam int unsigned FB    = frac_pkg::FIELD_BITS;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_BITS - 1);

  // input fields at word width
  logic [W-1:0] in_an, in_ad, in_bn, in_bd;

  generate
    if (W <= FB) begin : g_in_trunc
      assign in_an = in_tdata[W-1:0];
      assign in_ad = in_tdata[FB+W-1:FB];
      assign in_bn = in_tdata[2*FB+W-1:2*FB];
      assign in_bd = in_tdata[3*FB+W-1:3*FB];
    end else begin : g_in_sext
      assign in_an = {{(W-FB){in_tdata[FB-1]}},   in_tdata[FB-1:0]};
      assign in_ad = {{(W-FB){in_tdata[2*FB-1]}}, in_tdata[2*FB-1:FB]};
      assign in_bn = {{(W-FB){in_tdata[3*FB-1]}}, in_tdata[3*FB-1:2*FB]};
      assign in_bd = {{(W-FB){in_tdata[4*FB-1]}}, in_tdata[4*FB-1:3*FB]};
    end
  endgenerate

  frac_pkg::state_t  state_r, state_nxt;
  frac_pkg::kind_t   kind_r, kind_nxt;
  frac_pkg::div_op_t div_op_r, div_op_nxt;

  logic [W-1:0]     an_r, an_nxt, ad_r, ad_nxt, bn_r, bn_nxt, bd_r, bd_nxt;
  logic [W-1:0]     ea_r, ea_nxt, eb_r, eb_nxt;
  logic [W-1:0]     quo_r, quo_nxt, rem_r, rem_nxt, dsr_r, dsr_nxt;
  logic             div_neg_r, div_neg_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]     acc_r, acc_nxt, mcand_r, mcand_nxt, mplier_r, mplier_nxt;
  logic [1:0]       mul_idx_r, mul_idx_nxt;
  // products: an*bd, ad*bn, ad*bd, an*bn
  logic [W-1:0]     prod_r [4];
  logic [W-1:0]     prod_nxt [4];
  logic [W-1:0]     sum_r, sum_nxt, diff_r, diff_nxt, neg_r, neg_nxt;
  logic             zd_r, zd_nxt;

  // shared add/subtract unit
  logic [AW-1:0] add_x, add_y;
  logic          add_sub;
  logic [AW:0]   add_res;

  assign add_res = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)}
                 + {{AW{1'b0}}, add_sub};

  logic [AW-1:0] trial;
  assign trial = {rem_r, quo_r[W-1]};

  always_comb begin
    state_nxt   = state_r;
    kind_nxt    = kind_r;
    div_op_nxt  = div_op_r;
    an_nxt      = an_r;
    ad_nxt      = ad_r;
    bn_nxt      = bn_r;
    bd_nxt      = bd_r;
    ea_nxt      = ea_r;
    eb_nxt      = eb_r;
    quo_nxt     = quo_r;
    rem_nxt     = rem_r;
    dsr_nxt     = dsr_r;
    div_neg_nxt = div_neg_r;
    cnt_nxt     = cnt_r;
    acc_nxt     = acc_r;
    mcand_nxt   = mcand_r;
    mplier_nxt  = mplier_r;
    mul_idx_nxt = mul_idx_r;
    for (int i = 0; i < 4; i++) prod_nxt[i] = prod_r[i];
    sum_nxt     = sum_r;
    diff_nxt    = diff_r;
    neg_nxt     = neg_r;
    zd_nxt      = zd_r;
    add_x       = '0;
    add_y       = '0;
    add_sub     = 1'b0;

    unique case (state_r)
      frac_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          an_nxt    = in_an;
          ad_nxt    = in_ad;
          bn_nxt    = in_bn;
          bd_nxt    = in_bd;
          ea_nxt    = in_an;
          eb_nxt    = in_ad;
          zd_nxt    = 1'b0;
          state_nxt = frac_pkg::ST_EUC_TEST;
        end
      end
      frac_pkg::ST_EUC_TEST: begin
        if (eb_r == '0) begin
          state_nxt = frac_pkg::ST_RED;
        end else begin
          quo_nxt     = ea_r;
          dsr_nxt     = eb_r;
          div_neg_nxt = ea_r[W-1];
          div_op_nxt  = frac_pkg::OP_EUC;
          state_nxt   = frac_pkg::ST_DIV_MAGA;
        end
      end
      frac_pkg::ST_DIV_MAGA: begin
        add_y     = {1'b0, quo_r};
        add_sub   = quo_r[W-1];
        quo_nxt   = add_res[W-1:0];
        state_nxt = frac_pkg::ST_DIV_MAGB;
      end
      frac_pkg::ST_DIV_MAGB: begin
        add_y     = {1'b0, dsr_r};
        add_sub   = dsr_r[W-1];
        dsr_nxt   = add_res[W-1:0];
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = frac_pkg::ST_DIV_RUN;
      end
      frac_pkg::ST_DIV_RUN: begin
        // restoring step: carry out means the trial remainder covers the divisor
        add_x   = trial;
        add_y   = {1'b0, dsr_r};
        add_sub = 1'b1;
        rem_nxt = add_res[AW] ? add_res[W-1:0] : trial[W-1:0];
        quo_nxt = {quo_r[W-2:0], add_res[AW]};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) state_nxt = frac_pkg::ST_DIV_SIGN;
      end
      frac_pkg::ST_DIV_SIGN: begin
        add_y   = {1'b0, (div_op_r == frac_pkg::OP_EUC) ? rem_r : quo_r};
        add_sub = div_neg_r;
        unique case (div_op_r)
          frac_pkg::OP_EUC: begin
            ea_nxt    = eb_r;
            eb_nxt    = add_res[W-1:0];
            state_nxt = frac_pkg::ST_EUC_TEST;
          end
          frac_pkg::OP_QN: begin
            an_nxt      = add_res[W-1:0];
            quo_nxt     = ad_r;
            dsr_nxt     = ea_r;
            div_neg_nxt = ad_r[W-1] ^ ea_r[W-1];
            div_op_nxt  = frac_pkg::OP_QD;
            state_nxt   = frac_pkg::ST_DIV_MAGA;
          end
          frac_pkg::OP_QD: begin
            ad_nxt      = add_res[W-1:0];
            mul_idx_nxt = '0;
            state_nxt   = frac_pkg::ST_MUL_SETUP;
          end
          default: state_nxt = frac_pkg::ST_IDLE;
        endcase
      end
      frac_pkg::ST_RED: begin
        if (ea_r == '0) begin
          // 0/0: pass the first fraction through and flag it
          zd_nxt      = 1'b1;
          mul_idx_nxt = '0;
          state_nxt   = frac_pkg::ST_MUL_SETUP;
        end else begin
          quo_nxt     = an_r;
          dsr_nxt     = ea_r;
          div_neg_nxt = an_r[W-1] ^ ea_r[W-1];
          div_op_nxt  = frac_pkg::OP_QN;
          state_nxt   = frac_pkg::ST_DIV_MAGA;
        end
      end
      frac_pkg::ST_MUL_SETUP: begin
        unique case (mul_idx_r)
          2'd0: begin mcand_nxt = an_r; mplier_nxt = bd_r; end
          2'd1: begin mcand_nxt = ad_r; mplier_nxt = bn_r; end
          2'd2: begin mcand_nxt = ad_r; mplier_nxt = bd_r; end
          default: begin mcand_nxt = an_r; mplier_nxt = bn_r; end
        endcase
        acc_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = frac_pkg::ST_MUL_RUN;
      end
      frac_pkg::ST_MUL_RUN: begin
        add_x      = {1'b0, acc_r};
        add_y      = {1'b0, (mplier_r[0] ? mcand_r : {W{1'b0}})};
        acc_nxt    = add_res[W-1:0];
        mcand_nxt  = {mcand_r[W-2:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[W-1:1]};
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          prod_nxt[mul_idx_r] = add_res[W-1:0];
          mul_idx_nxt         = mul_idx_r + 1'b1;
          state_nxt = (mul_idx_r == 2'd3) ? frac_pkg::ST_SUM : frac_pkg::ST_MUL_SETUP;
        end
      end
      frac_pkg::ST_SUM: begin
        add_x     = {1'b0, prod_r[0]};
        add_y     = {1'b0, prod_r[1]};
        sum_nxt   = add_res[W-1:0];
        state_nxt = frac_pkg::ST_DIFF;
      end
      frac_pkg::ST_DIFF: begin
        add_x     = {1'b0, prod_r[0]};
        add_y     = {1'b0, prod_r[1]};
        add_sub   = 1'b1;
        diff_nxt  = add_res[W-1:0];
        state_nxt = frac_pkg::ST_NEG;
      end
      frac_pkg::ST_NEG: begin
        add_y     = {1'b0, an_r};
        add_sub   = 1'b1;
        neg_nxt   = add_res[W-1:0];
        kind_nxt  = frac_pkg::KIND_REDUCED;
        state_nxt = frac_pkg::ST_EMIT;
      end
      frac_pkg::ST_EMIT: begin
        if (out_tready) begin
          if (kind_r == frac_pkg::KIND_QUOTIENT) begin
            kind_nxt  = frac_pkg::KIND_REDUCED;
            state_nxt = frac_pkg::ST_IDLE;
          end else begin
            kind_nxt = frac_pkg::kind_t'(kind_r + 3'd1);
          end
        end
      end
      default: state_nxt = frac_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= frac_pkg::ST_IDLE;
      kind_r    <= frac_pkg::KIND_REDUCED;
      div_op_r  <= frac_pkg::OP_EUC;
      mul_idx_r <= '0;
      cnt_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      kind_r    <= kind_nxt;
      div_op_r  <= div_op_nxt;
      mul_idx_r <= mul_idx_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    an_r      <= an_nxt;
    ad_r      <= ad_nxt;
    bn_r      <= bn_nxt;
    bd_r      <= bd_nxt;
    ea_r      <= ea_nxt;
    eb_r      <= eb_nxt;
    quo_r     <= quo_nxt;
    rem_r     <= rem_nxt;
    dsr_r     <= dsr_nxt;
    div_neg_r <= div_neg_nxt;
    acc_r     <= acc_nxt;
    mcand_r   <= mcand_nxt;
    mplier_r  <= mplier_nxt;
    for (int i = 0; i < 4; i++) prod_r[i] <= prod_nxt[i];
    sum_r     <= sum_nxt;
    diff_r    <= diff_nxt;
    neg_r     <= neg_nxt;
    zd_r      <= zd_nxt;
  end

  // result selection
  logic [W-1:0]  sel_num, sel_den;
  logic [FB-1:0] res_num, res_den;

  always_comb begin
    case (kind_r)
      frac_pkg::KIND_REDUCED:  begin sel_num = an_r;      sel_den = ad_r;      end
      frac_pkg::KIND_SUM:      begin sel_num = sum_r;     sel_den = prod_r[2]; end
      frac_pkg::KIND_DIFF:     begin sel_num = diff_r;    sel_den = prod_r[2]; end
      frac_pkg::KIND_NEG:      begin sel_num = neg_r;     sel_den = ad_r;      end
      frac_pkg::KIND_PRODUCT:  begin sel_num = prod_r[3]; sel_den = prod_r[2]; end
      frac_pkg::KIND_QUOTIENT: begin sel_num = prod_r[0]; sel_den = prod_r[1]; end
      default:                 begin sel_num = '0;        sel_den = '0;        end
    endcase
  end

  generate
    if (W >= FB) begin : g_out_trunc
      assign res_num = sel_num[FB-1:0];
      assign res_den = sel_den[FB-1:0];
    end else begin : g_out_sext
      assign res_num = {{(FB-W){sel_num[W-1]}}, sel_num};
      assign res_den = {{(FB-W){sel_den[W-1]}}, sel_den};
    end
  endgenerate

  assign in_tready  = (state_r == frac_pkg::ST_IDLE);
  assign out_tvalid = (state_r == frac_pkg::ST_EMIT);
  assign out_tdata  = {res_den, res_num};
  assign out_tuser  = {zd_r, kind_r};
  assign out_tlast  = (kind_r == frac_pkg::KIND_QUOTIENT);

  // checks
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input taken while results pending");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> in_tready)
    else $error("not idle after final result");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready && !out_tvalid)
    else $error("sequencer did not start on accepted item");

  a_nonzero_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == frac_pkg::ST_DIV_RUN |-> dsr_r != '0)
    else $error("division by zero in shared unit");

  a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == frac_pkg::ST_DIV_RUN && cnt_r != CNT_LAST
      |=> state_r == frac_pkg::ST_DIV_RUN)
    else $error("division left early");

endmodule
